// ----- sv/lfpf_pkg.sv -----
// Shared types, constants and the tone/gamma ROM contents of the LED frame post filter.
`default_nettype none

package lfpf_pkg;

    localparam int SUM_LEVELS = 1021;
    localparam int SUM_W      = 10;
    localparam int JOB_DEPTH  = 4;

    localparam logic [31:0] INDEX_KEY   = 32'h9E37_79B1;
    localparam logic [31:0] FRAME_KEY   = 32'h3C6E_F35F;
    localparam logic [31:0] MIX_MUL_A   = 32'h7FEB_352D;
    localparam logic [31:0] MIX_MUL_B   = 32'h846C_A68B;
    localparam logic [7:0]  ALPHA_RESET = 8'd40;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       end_of_frame;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] pixel_index;
        logic       frame_last;
    } t_pixel_out;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [31:0]      seed;
        logic             last;
    } t_job_core;

    typedef struct packed {
        logic first;
        logic second;
    } t_job_push;

    typedef logic [SUM_LEVELS-1:0][7:0] t_tone_rom;

    function automatic logic [7:0] gamma_of(input logic [7:0] t);
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [7:0]   best;
        logic [7:0]   cand;
        rhs  = 128'd2048;
        best = 8'd0;
        for (int k = 0; k < 5; k++) begin
            rhs = rhs * 128'(t);
        end
        for (int k = 0; k < 6; k++) begin
            rhs = rhs * 128'd255;
        end
        for (int b = 7; b >= 0; b--) begin
            cand = best | (8'd1 << b);
            lhs  = 128'd1;
            for (int k = 0; k < 11; k++) begin
                lhs = lhs * (128'(cand) * 128'd2 - 128'd1);
            end
            if (lhs <= rhs) begin
                best = cand;
            end
        end
        return best;
    endfunction

    function automatic t_tone_rom build_tone_rom();
        t_tone_rom  rom;
        logic [7:0] gtab [256];
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] lim;
        logic [7:0]  t;
        logic [7:0]  cand;
        for (int i = 0; i < 256; i++) begin
            gtab[i] = gamma_of(8'(i));
        end
        for (int s = 0; s < SUM_LEVELS; s++) begin
            num = 64'(s) * (64'd251 * 64'(s) + 64'd3600);
            den = 64'(s) * (64'd243 * 64'(s) + 64'd70800) + 64'd20160000;
            lim = 64'd510 * num + den;
            t   = 8'd0;
            for (int b = 7; b >= 0; b--) begin
                cand = t | (8'd1 << b);
                if (64'd2 * den * 64'(cand) <= lim) begin
                    t = cand;
                end
            end
            rom[s] = gtab[t];
        end
        return rom;
    endfunction

    localparam t_tone_rom TONE_ROM = build_tone_rom();

endpackage

`default_nettype wire

// ----- sv/lfpf_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lfpf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/lfpf_front.sv -----
// Front end: pixel window, frame bookkeeping and job generation.
`default_nettype none

module lfpf_front import lfpf_pkg::*; #(
    parameter int MAX_PIXELS = 256,
    localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int CNT_W = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_pixel_in  i_pixel,
    output logic            o_full,
    input  wire logic       i_room,
    output t_job_push       o_push,
    output t_job_core       o_job_a,
    output logic [IDX_W-1:0] o_idx_a,
    output t_job_core       o_job_b,
    output logic [IDX_W-1:0] o_idx_b
);

    logic [23:0]      r_left;
    logic [23:0]      r_center;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_ikey;
    logic [31:0]      r_fkey;

    logic             accept;
    logic             below;
    logic             k_zero;
    logic             eof;
    logic [23:0]      px;
    logic [23:0]      new_left;
    logic [31:0]      key_prev;
    t_job_core        job_x;
    t_job_core        job_y;
    t_job_core        job_z;
    logic [IDX_W-1:0] idx_x;
    logic [IDX_W-1:0] idx_y;
    logic [IDX_W-1:0] idx_z;

    function automatic logic [SUM_W-1:0] chan_sum(input logic [7:0] l, c, r);
        return SUM_W'(l) + SUM_W'({c, 1'b0}) + SUM_W'(r);
    endfunction

    function automatic t_job_core make_job(input logic [23:0] l, c, r, input logic last,
                                           input logic [31:0] seed);
        t_job_core j;
        j.sum_red   = chan_sum(l[23:16], c[23:16], r[23:16]);
        j.sum_green = chan_sum(l[15:8], c[15:8], r[15:8]);
        j.sum_blue  = chan_sum(l[7:0], c[7:0], r[7:0]);
        j.seed      = seed;
        j.last      = last;
        return j;
    endfunction

    assign o_full = !i_room;
    assign accept = i_push && i_room;
    assign below  = r_count < CNT_W'(MAX_PIXELS);
    assign k_zero = r_count == '0;
    assign eof    = i_pixel.end_of_frame;
    assign px     = {i_pixel.red_in, i_pixel.green_in, i_pixel.blue_in};

    always_comb begin
        new_left = k_zero ? px : r_center;
        key_prev = r_ikey - INDEX_KEY;
        job_x    = make_job(r_left, r_center, px, 1'b0, key_prev ^ r_fkey);
        idx_x    = IDX_W'(r_count - CNT_W'(1));
        job_y    = make_job(new_left, px, px, 1'b1, r_ikey ^ r_fkey);
        idx_y    = IDX_W'(r_count);
        job_z    = make_job(r_left, r_center, r_center, 1'b1, key_prev ^ r_fkey);
        idx_z    = IDX_W'(MAX_PIXELS - 1);
        o_push   = '0;
        o_job_a  = job_x;
        o_idx_a  = idx_x;
        o_job_b  = job_y;
        o_idx_b  = idx_y;
        if (accept) begin
            if (below) begin
                if (!k_zero) begin
                    o_push.first  = 1'b1;
                    o_push.second = eof;
                end else if (eof) begin
                    o_push.first = 1'b1;
                    o_job_a      = job_y;
                    o_idx_a      = idx_y;
                end
            end else if (eof) begin
                o_push.first = 1'b1;
                o_job_a      = job_z;
                o_idx_a      = idx_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_center <= '0;
            r_count  <= '0;
            r_ikey   <= INDEX_KEY;
            r_fkey   <= '0;
        end else if (accept) begin
            if (below) begin
                r_left   <= new_left;
                r_center <= px;
                r_count  <= r_count + CNT_W'(1);
                r_ikey   <= r_ikey + INDEX_KEY;
            end
            if (eof) begin
                r_count <= '0;
                r_ikey  <= INDEX_KEY;
                r_fkey  <= r_fkey + FRAME_KEY;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PIXELS))
        else $error("arrival count past limit");
    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.second |-> (o_push.first && eof && !k_zero))
        else $error("second job without first");
`endif

endmodule

`default_nettype wire

// ----- sv/lfpf_job_queue.sv -----
// Four-entry job queue between front and back, up to two pushes per cycle.
`default_nettype none

module lfpf_job_queue import lfpf_pkg::*; #(
    parameter int MAX_PIXELS = 256,
    localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_job_push        i_push,
    input  wire t_job_core        i_job_a,
    input  wire logic [IDX_W-1:0] i_idx_a,
    input  wire t_job_core        i_job_b,
    input  wire logic [IDX_W-1:0] i_idx_b,
    output logic                  o_room,
    output logic                  o_valid,
    output t_job_core             o_job,
    output logic [IDX_W-1:0]      o_idx,
    input  wire logic             i_pop
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int QC_W  = $clog2(JOB_DEPTH + 1);

    t_job_core        r_core [JOB_DEPTH];
    logic [IDX_W-1:0] r_idx  [JOB_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [QC_W-1:0]  r_count;
    logic [PTR_W-1:0] wp_next;

    assign wp_next = r_wp + PTR_W'(1);
    assign o_room  = r_count <= QC_W'(JOB_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_job   = r_core[r_rp];
    assign o_idx   = r_idx[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_core[r_wp] <= i_job_a;
            r_idx[r_wp]  <= i_idx_a;
        end
        if (i_push.second) begin
            r_core[wp_next] <= i_job_b;
            r_idx[wp_next]  <= i_idx_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(i_push.first) + PTR_W'(i_push.second);
            r_rp    <= r_rp + PTR_W'(i_pop);
            r_count <= r_count + QC_W'(i_push.first) + QC_W'(i_push.second) - QC_W'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ----- sv/lfpf_back.sv -----
// Back end: hash dither, tone ROM, EMA against the history memory, result register.
`default_nettype none

module lfpf_back import lfpf_pkg::*; #(
    parameter int MAX_PIXELS = 256,
    localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1,
    localparam int CNT_W = $clog2(MAX_PIXELS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire t_job_core        i_job,
    input  wire logic [IDX_W-1:0] i_job_idx,
    output logic                  o_job_pop,
    input  wire logic             i_cfg_valid,
    input  wire logic [7:0]       i_cfg_ema_alpha,
    output logic                  o_cfg_ready,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output t_pixel_out            o_pixel
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH_A,
        S_HASH_B,
        S_CHAN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_ch;
    t_job_core        r_job;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_h;
    logic [7:0]       r_tone [3];
    logic [7:0]       r_prev [3];
    logic [7:0]       r_res  [2];
    logic [7:0]       r_tone_q;
    t_pixel_out       r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_fill;
    logic [7:0]       r_alpha;

    logic             out_free;
    logic             finish;
    logic [SUM_W-1:0] rom_addr;
    logic [31:0]      mul_a;
    logic [31:0]      mul_k;
    logic [31:0]      mul_p;
    logic [1:0]       dcode;
    logic [7:0]       ch_val;
    logic             ram_re;
    logic [23:0]      ram_q;
    logic [23:0]      prev_word;

    function automatic logic [7:0] ema(input logic [7:0] tone, input logic [1:0] dc,
                                       input logic [7:0] prev, input logic [7:0] alpha);
        logic signed [9:0]  v;
        logic [7:0]         vc;
        logic signed [9:0]  diff;
        logic signed [18:0] prod;
        logic signed [10:0] step;
        logic signed [10:0] o;
        v    = signed'({2'b00, tone}) + signed'({8'b0, dc}) - 10'sd1;
        vc   = (v < 10'sd0) ? 8'd0 : ((v > 10'sd255) ? 8'd255 : v[7:0]);
        diff = signed'({2'b00, vc}) - signed'({2'b00, prev});
        prod = diff * signed'({1'b0, alpha});
        step = prod[18:8];
        o    = signed'({3'b000, prev}) + step;
        return (o < 11'sd0) ? 8'd0 : ((o > 11'sd255) ? 8'd255 : o[7:0]);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_empty     = !r_out_valid;
    assign o_pixel     = r_out;
    assign out_free    = !r_out_valid || i_pop;
    assign finish      = (r_state == S_CHAN) && (r_ch == 2'd2) && out_free;
    assign o_job_pop   = i_job_valid && ((r_state == S_IDLE) || finish);
    assign ram_re      = r_state == S_HASH_A;
    assign dcode       = r_h[1:0] ^ r_h[17:16];
    assign ch_val      = ema(r_tone[r_ch], dcode, r_prev[r_ch], r_alpha);
    assign prev_word   = (CNT_W'(r_idx) < r_fill) ? ram_q : 24'd0;

    always_comb begin
        unique case (r_state)
            S_HASH_A: rom_addr = r_job.sum_red;
            S_HASH_B: rom_addr = r_job.sum_green;
            default:  rom_addr = r_job.sum_blue;
        endcase
    end

    always_comb begin
        if (r_state == S_HASH_A) begin
            mul_a = r_job.seed ^ (r_job.seed >> 16);
            mul_k = MIX_MUL_A;
        end else begin
            mul_a = r_h ^ (r_h >> 15);
            mul_k = MIX_MUL_B;
        end
        mul_p = mul_a * mul_k;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = S_HASH_A;
                end
            end
            S_HASH_A: n_state = S_HASH_B;
            S_HASH_B: n_state = S_CHAN;
            S_CHAN: begin
                if (finish) begin
                    n_state = i_job_valid ? S_HASH_A : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tone_q <= TONE_ROM[rom_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 2'd0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_alpha     <= ALPHA_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_alpha <= i_cfg_ema_alpha;
            end
            if (o_job_pop) begin
                r_job <= i_job;
                r_idx <= i_job_idx;
            end
            unique case (r_state)
                S_HASH_A: begin
                    r_h <= mul_p;
                end
                S_HASH_B: begin
                    r_h       <= mul_p;
                    r_tone[0] <= r_tone_q;
                    r_prev[0] <= prev_word[23:16];
                    r_prev[1] <= prev_word[15:8];
                    r_prev[2] <= prev_word[7:0];
                    r_ch      <= 2'd0;
                end
                S_CHAN: begin
                    if (r_ch == 2'd0) begin
                        r_tone[1] <= r_tone_q;
                        r_res[0]  <= ch_val;
                        r_ch      <= 2'd1;
                    end else if (r_ch == 2'd1) begin
                        r_tone[2] <= r_tone_q;
                        r_res[1]  <= ch_val;
                        r_ch      <= 2'd2;
                    end
                end
                default: begin
                end
            endcase
            if (finish) begin
                r_out_valid       <= 1'b1;
                r_out.red_out     <= r_res[0];
                r_out.green_out   <= r_res[1];
                r_out.blue_out    <= ch_val;
                r_out.pixel_index <= 8'(r_idx);
                r_out.frame_last  <= r_job.last;
                if (CNT_W'(r_idx) == r_fill) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    lfpf_ram #(
        .WIDTH (24),
        .DEPTH (MAX_PIXELS)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (finish),
        .i_waddr (r_idx),
        .i_wdata ({r_res[0], r_res[1], ch_val}),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_q)
    );

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_PIXELS))
        else $error("history fill past depth");
    a_write_in_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> (CNT_W'(r_idx) <= r_fill))
        else $error("history write leaves a gap");
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> !o_empty)
        else $error("finished beat not presented");
    a_pop_starts_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == S_HASH_A))
        else $error("job popped without starting");
`endif

endmodule

`default_nettype wire

// ----- sv/led_frame_post_filter_unit.sv -----
// LED frame post filter: blur, tone map with gamma, hash dither and temporal EMA per pixel.
// Pixels enter through push/full; results leave through empty/pop. A pixel's result
// leaves once the next pixel of the frame has arrived, and the end-of-frame pixel also
// releases the frame's last result. The front end takes one pixel per cycle while its
// four-entry job queue has room for two jobs. The back end works on each result in
// steps: two on its single 32x32 hash multiplier, then one per color channel on the
// single-port tone ROM and the EMA multiplier; the previous-frame memory is read and
// written once per result. The result register holds one finished beat, so the back
// end stalls only while it is still unpopped. The previous-frame memory needs no
// clearing pass after reset: a fill count marks which entries hold data, and unwritten
// entries read as black. Pixels at index MAX_PIXELS and beyond are dropped. The user
// must write ema_alpha only while the unit is idle; the unit does not enforce this.
`default_nettype none

module led_frame_post_filter_unit import lfpf_pkg::*; #(
    parameter int MAX_PIXELS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire t_pixel_in  i_pixel,
    output logic            empty,
    input  wire logic       pop,
    output t_pixel_out      o_pixel,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_ema_alpha
);

    localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    t_job_push        job_push;
    t_job_core        job_a;
    t_job_core        job_b;
    t_job_core        job_head;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_head;
    logic             room;
    logic             job_valid;
    logic             job_pop;

    lfpf_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pixel (i_pixel),
        .o_full  (full),
        .i_room  (room),
        .o_push  (job_push),
        .o_job_a (job_a),
        .o_idx_a (idx_a),
        .o_job_b (job_b),
        .o_idx_b (idx_b)
    );

    lfpf_job_queue #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job_a (job_a),
        .i_idx_a (idx_a),
        .i_job_b (job_b),
        .i_idx_b (idx_b),
        .o_room  (room),
        .o_valid (job_valid),
        .o_job   (job_head),
        .o_idx   (idx_head),
        .i_pop   (job_pop)
    );

    lfpf_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job_head),
        .i_job_idx       (idx_head),
        .o_job_pop       (job_pop),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ema_alpha (i_cfg_ema_alpha),
        .o_cfg_ready     (o_cfg_ready),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_pixel         (o_pixel)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for led_frame_post_filter_unit: blur, tone/gamma, dither and EMA prediction.

module testbench;
    import lfpf_pkg::*;

    localparam int          PIXEL_CAP     = 256;
    localparam int          SUM_TOP       = 1020;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_ITEMS  = 1500;
    localparam int          TOTAL_ITEMS   = 1650;
    localparam logic [7:0]  ALPHA_LOW     = 8'd40;
    localparam logic [7:0]  ALPHA_HIGH    = 8'd160;
    localparam logic [31:0] POS_KEY       = 32'h9e37_79b1;
    localparam logic [31:0] FRAME_STEP    = 32'h3c6e_f35f;
    localparam logic [31:0] SCRAMBLE_A    = 32'h7feb_352d;
    localparam logic [31:0] SCRAMBLE_B    = 32'h846c_a68b;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_pixel_in  i_pixel;
    logic       empty;
    logic       pop;
    t_pixel_out o_pixel;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_ema_alpha;

    logic [7:0]  tone_lut [SUM_TOP + 1];
    logic [23:0] history [PIXEL_CAP];
    logic [23:0] win_left;
    logic [23:0] win_center;
    int          arrivals;
    logic [31:0] frames_done;
    logic [7:0]  ema_weight;

    t_pixel_out expected_pixels [$];
    int         mismatches;
    int         pixels_sent;
    int         cycle_count;
    bit         gaps_on;
    bit         hold_request;

    led_frame_post_filter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_pixel         (i_pixel),
        .empty           (empty),
        .pop             (pop),
        .o_pixel         (o_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_ema_alpha (i_cfg_ema_alpha)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [7:0] gamma_code(input int unsigned level);
        logic [127:0] bound;
        logic [127:0] power;
        int           best;
        bound = 128'd2048;
        best  = 0;
        repeat (5) bound = bound * level;
        repeat (6) bound = bound * 128'd255;
        for (int g = 1; g <= 255; g++) begin
            power = 128'd1;
            repeat (11) power = power * (2 * g - 1);
            if (power > bound) break;
            best = g;
        end
        return best[7:0];
    endfunction

    task automatic build_tone_lut();
        logic [7:0]      gamma_tab [256];
        longint unsigned sl;
        longint unsigned num;
        longint unsigned den;
        longint unsigned level;
        for (int t = 0; t < 256; t++) gamma_tab[t] = gamma_code(t);
        for (int s = 0; s <= SUM_TOP; s++) begin
            sl    = s;
            num   = sl * (251 * sl + 3600);
            den   = sl * (243 * sl + 70800) + 20160000;
            level = (510 * num + den) / (2 * den);
            if (level > 255) level = 255;
            tone_lut[s] = gamma_tab[level];
        end
    endtask

    function automatic logic [31:0] scramble(input logic [31:0] x);
        x = x ^ (x >> 16);
        x = x * SCRAMBLE_A;
        x = x ^ (x >> 15);
        x = x * SCRAMBLE_B;
        return x ^ (x >> 16);
    endfunction

    task automatic produce_pixel(input int idx, input logic [23:0] lft, input logic [23:0] ctr,
                                 input logic [23:0] rgt, input logic last);
        logic [31:0] pos;
        logic [31:0] h;
        logic [23:0] prev;
        logic [23:0] rgb;
        int          dith;
        int          sum;
        int          v;
        int          p;
        int          o;
        t_pixel_out  res;
        pos  = idx + 1;
        h    = scramble((pos * POS_KEY) ^ (frames_done * FRAME_STEP));
        dith = int'(h[1:0]) - 1;
        prev = history[idx % PIXEL_CAP];
        for (int sh = 16; sh >= 0; sh -= 8) begin
            sum = lft[sh +: 8] + 2 * ctr[sh +: 8] + rgt[sh +: 8];
            v   = int'(tone_lut[sum]) + dith;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            p = int'(prev[sh +: 8]);
            o = p + (((v - p) * int'(ema_weight)) >>> 8);
            if (o < 0) o = 0;
            if (o > 255) o = 255;
            rgb[sh +: 8] = o[7:0];
        end
        history[idx % PIXEL_CAP] = rgb;
        res.red_out     = rgb[23:16];
        res.green_out   = rgb[15:8];
        res.blue_out    = rgb[7:0];
        res.pixel_index = idx[7:0];
        res.frame_last  = last;
        expected_pixels.push_back(res);
    endtask

    task automatic filter_pixel(input logic [23:0] rgb, input logic eof);
        if (arrivals < PIXEL_CAP) begin
            if (arrivals == 0) begin
                win_left   = rgb;
                win_center = rgb;
            end else begin
                produce_pixel(arrivals - 1, win_left, win_center, rgb, 1'b0);
                win_left   = win_center;
                win_center = rgb;
            end
            if (eof) produce_pixel(arrivals, win_left, win_center, rgb, 1'b1);
            arrivals++;
        end else if (eof) begin
            produce_pixel(PIXEL_CAP - 1, win_left, win_center, win_center, 1'b1);
        end
        if (eof) begin
            arrivals    = 0;
            frames_done = frames_done + 1;
        end
    endtask

    task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    initial begin : result_check
        int         stall_left;
        t_pixel_out want;
        stall_left = 0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected beat, expected none, got index %0d",
                             $time, o_pixel.pixel_index);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red_out", want.red_out, o_pixel.red_out);
                    check_field("green_out", want.green_out, o_pixel.green_out);
                    check_field("blue_out", want.blue_out, o_pixel.blue_out);
                    check_field("pixel_index", want.pixel_index, o_pixel.pixel_index);
                    check_field("frame_last", want.frame_last, o_pixel.frame_last);
                end
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [23:0] random_pixel();
        logic [23:0] rgb;
        rgb = 24'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            for (int c = 0; c < 24; c += 8) rgb[c +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return rgb;
    endfunction

    task automatic send_pixel(input logic [23:0] rgb, input logic eof);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_pixel <= {rgb, eof};
        push    <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        filter_pixel(rgb, eof);
        pixels_sent++;
    endtask

    task automatic send_frame(input int length);
        for (int n = 0; n < length; n++) send_pixel(random_pixel(), n == length - 1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_alpha(input logic [7:0] value);
        wait_drained();
        i_cfg_ema_alpha <= value;
        i_cfg_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ema_weight = value;
    endtask

    task automatic test_edge_pixels();
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hffffff, 1'b1);
        send_pixel(24'hff0080, 1'b0);
        send_pixel(24'h00ff7f, 1'b1);
        send_pixel(24'hffffff, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hff00ff, 1'b0);
        send_pixel(24'h01fe55, 1'b1);
    endtask

    task automatic test_alpha_extremes();
        logic [7:0] weights [3];
        weights = '{8'hff, 8'h00, ALPHA_HIGH};
        foreach (weights[w]) begin
            set_alpha(weights[w]);
            send_pixel(24'hffffff, 1'b0);
            send_pixel(24'h000000, 1'b0);
            send_pixel(24'hffffff, 1'b1);
        end
        set_alpha(ALPHA_LOW);
    endtask

    task automatic test_frame_overrun();
        send_frame(PIXEL_CAP);
        send_frame(PIXEL_CAP + 1);
        send_frame(PIXEL_CAP + 44);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        send_frame(40);
        wait_drained();
    endtask

    task automatic pick_alpha();
        case ($urandom_range(0, 3))
            0:       set_alpha(ALPHA_LOW);
            1:       set_alpha(ALPHA_HIGH);
            2:       set_alpha(8'($urandom_range(ALPHA_LOW, ALPHA_HIGH)));
            default: set_alpha(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic test_random_frames();
        while (pixels_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) pick_alpha();
            if ($urandom_range(0, 11) == 0) send_frame($urandom_range(25, 120));
            else send_frame($urandom_range(1, 24));
        end
        wait_drained();
    endtask

    task automatic test_steady_tail();
        gaps_on = 1'b0;
        pick_alpha();
        while (pixels_sent < TOTAL_ITEMS) send_frame($urandom_range(1, 30));
        wait_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        i_pixel         <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_ema_alpha <= '0;
        cycle_count  = 0;
        mismatches   = 0;
        pixels_sent  = 0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        arrivals     = 0;
        frames_done  = '0;
        win_left     = '0;
        win_center   = '0;
        ema_weight   = ALPHA_LOW;
        foreach (history[j]) history[j] = '0;
        build_tone_lut();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_pixels();
        test_alpha_extremes();
        test_frame_overrun();
        test_output_backpressure();
        test_random_frames();
        test_steady_tail();

        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
